@@ hdl/double_buffered_led_framebuffer_assert.svh @@
// Assertion macros for the LED frame store, clocked on clk_i, off during reset.
`ifndef DOUBLE_BUFFERED_LED_FRAMEBUFFER_ASSERT_SVH
`define DOUBLE_BUFFERED_LED_FRAMEBUFFER_ASSERT_SVH

// same-cycle implication
`define DBLF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DBLF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/dblf_pkg.sv @@
// Shared constants and opcode codes for the LED frame store.
package dblf_pkg;

  localparam int SCREEN_COLS_DEF = 32;
  localparam int SCREEN_ROWS_DEF = 16;
  localparam int COORD_W         = 8;
  localparam int BYTE_W          = 8;
  localparam int OP_W            = 3;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 3'd0,
    OP_FILL    = 3'd1,
    OP_PRESENT = 3'd2,
    OP_ACK     = 3'd3,
    OP_TICK    = 3'd4
  } op_e;

endpackage

@@ hdl/dblf_raster.sv @@
// Rectangle walker: emits one in-bank pixel write address per cycle in raster order.
module dblf_raster #(
  parameter int SCREEN_COLS = dblf_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = dblf_pkg::SCREEN_ROWS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [dblf_pkg::COORD_W-1:0] x0_i,
  input  logic [dblf_pkg::COORD_W-1:0] y0_i,
  input  logic [dblf_pkg::COORD_W-1:0] x1_i,
  input  logic [dblf_pkg::COORD_W-1:0] y1_i,
  output logic                         we_o,
  output logic [$clog2(2*SCREEN_COLS*SCREEN_ROWS)-1:0] addr_o,
  output logic                         done_o
);

  localparam int ADDR_W = $clog2(2 * SCREEN_COLS * SCREEN_ROWS);
  localparam int CW     = dblf_pkg::COORD_W;

  typedef enum logic [1:0] {
    W_IDLE,
    W_SETUP,
    W_RUN
  } wstate_e;

  wstate_e           state_q;
  logic [CW-1:0]     x0_q, y0_q, x1_q, y1_q;
  logic [CW-1:0]     col_q, row_q;
  logic [ADDR_W-1:0] base_q;
  logic              done_q;
  logic              col_last, row_last;

  assign col_last = ({1'b0, col_q} + 9'd1) == {1'b0, x1_q};
  assign row_last = ({1'b0, row_q} + 9'd1) == {1'b0, y1_q};
  assign we_o     = (state_q == W_RUN);
  assign addr_o   = base_q + ADDR_W'(col_q);
  assign done_o   = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        W_IDLE: begin
          if (start_i) begin
            if ((x0_i >= x1_i) || (y0_i >= y1_i)) begin
              done_q <= 1'b1;
            end else begin
              state_q <= W_SETUP;
            end
          end
        end
        W_SETUP: begin
          state_q <= W_RUN;
        end
        W_RUN: begin
          if (col_last && row_last) begin
            state_q <= W_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= W_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == W_IDLE && start_i) begin
      x0_q <= x0_i;
      y0_q <= y0_i;
      x1_q <= x1_i;
      y1_q <= y1_i;
    end
    if (state_q == W_SETUP) begin
      base_q <= ADDR_W'(y0_q) * ADDR_W'(SCREEN_COLS);
      col_q  <= x0_q;
      row_q  <= y0_q;
    end else if (state_q == W_RUN) begin
      if (col_last) begin
        col_q  <= x0_q;
        row_q  <= row_q + CW'(1);
        base_q <= base_q + ADDR_W'(SCREEN_COLS);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

endmodule

@@ hdl/double_buffered_led_framebuffer.sv @@
// Double-buffered LED frame store: drawing ops, bank swap and byte-serial frame output.
//
// Commands: an item is taken on a clock edge with start_i high and busy_o low.
// Every item gives exactly one result, shown for one cycle with valid_o high;
// the receiver cannot stall, so each result is gone after that cycle.
// Path from accept to valid_o:
//   present, acknowledge, unused codes, tick with an acknowledge pending: registered on accept
//   tick that sends a pixel: one registered memory read, then the S_READ state
//   clear and fill rectangle: raster setup, one write per painted pixel, then raster done
//   fill rectangle that paints nothing: raster done at once, then the result
// Painting writes one pixel per cycle through the single write port of the
// two-bank store; that port sets the fill rate. busy_o stays high until the
// result is out, so one item is in work at a time.
// After reset the store is swept to zero, one entry a cycle, over all
// 2*SCREEN_COLS*SCREEN_ROWS entries (1024 at 32x16) with busy_o high.
// start_command_i must be written on start_command_we_i only while idle; the block does not check.
module double_buffered_led_framebuffer #(
  parameter int SCREEN_COLS = dblf_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = dblf_pkg::SCREEN_ROWS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_command_we_i,
  input  logic [dblf_pkg::BYTE_W-1:0]   start_command_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [dblf_pkg::OP_W-1:0]     opcode_i,
  input  logic [dblf_pkg::COORD_W-1:0]  area_x_i,
  input  logic [dblf_pkg::COORD_W-1:0]  area_y_i,
  input  logic [dblf_pkg::COORD_W-1:0]  area_width_i,
  input  logic [dblf_pkg::COORD_W-1:0]  area_height_i,
  input  logic [dblf_pkg::BYTE_W-1:0]   fill_color_i,
  output logic                          valid_o,
  output logic                          tx_valid_o,
  output logic [dblf_pkg::BYTE_W-1:0]   tx_byte_o,
  output logic                          frame_in_flight_o,
  output logic                          ack_pending_o
);

  localparam int BANK_SIZE = SCREEN_COLS * SCREEN_ROWS;
  localparam int DEPTH     = 2 * BANK_SIZE;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CW        = dblf_pkg::COORD_W;
  localparam int BW        = dblf_pkg::BYTE_W;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_PAINT,
    S_READ
  } state_e;

  state_e            state_q;
  logic [ADDR_W-1:0] init_q;
  logic [ADDR_W-1:0] pos_q;
  logic              front_q;
  logic              wait_q;
  logic              fbusy_q;
  logic [BW-1:0]     cmd_q;
  logic [BW-1:0]     color_q;
  logic              valid_q;
  logic              tx_valid_q;
  logic [BW-1:0]     tx_byte_q;

  logic [BW-1:0]     mem [DEPTH];
  logic [BW-1:0]     rd_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [BW-1:0]     mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  logic              accept;
  dblf_pkg::op_e     op;
  logic              rast_start;
  logic              rast_we;
  logic [ADDR_W-1:0] rast_addr;
  logic              rast_done;
  logic [CW-1:0]     x0, y0, x1, y1;
  logic [CW:0]       x_sum, y_sum;

  assign busy_o            = (state_q != S_IDLE);
  assign accept            = start_i && !busy_o;
  assign op                = dblf_pkg::op_e'(opcode_i);
  assign valid_o           = valid_q;
  assign tx_valid_o        = tx_valid_q;
  assign tx_byte_o         = tx_byte_q;
  assign frame_in_flight_o = fbusy_q;
  assign ack_pending_o     = wait_q;

  // clipped rectangle ends, sums kept one bit wider
  assign x_sum = {1'b0, area_x_i} + {1'b0, area_width_i};
  assign y_sum = {1'b0, area_y_i} + {1'b0, area_height_i};

  always_comb begin
    if (op == dblf_pkg::OP_CLEAR) begin
      x0 = '0;
      y0 = '0;
      x1 = CW'(SCREEN_COLS);
      y1 = CW'(SCREEN_ROWS);
    end else begin
      x0 = area_x_i;
      y0 = area_y_i;
      x1 = (x_sum > (CW+1)'(SCREEN_COLS)) ? CW'(SCREEN_COLS) : x_sum[CW-1:0];
      y1 = (y_sum > (CW+1)'(SCREEN_ROWS)) ? CW'(SCREEN_ROWS) : y_sum[CW-1:0];
    end
  end

  assign rast_start = accept && ((op == dblf_pkg::OP_CLEAR) || (op == dblf_pkg::OP_FILL));

  dblf_raster #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_raster (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rast_start),
    .x0_i    (x0),
    .y0_i    (y0),
    .x1_i    (x1),
    .y1_i    (y1),
    .we_o    (rast_we),
    .addr_o  (rast_addr),
    .done_o  (rast_done)
  );

  always_comb begin
    if (state_q == S_INIT) begin
      mem_we    = 1'b1;
      mem_waddr = init_q;
      mem_wdata = '0;
    end else begin
      mem_we    = rast_we;
      mem_waddr = front_q ? rast_addr : rast_addr + ADDR_W'(BANK_SIZE);
      mem_wdata = color_q;
    end
    mem_raddr = front_q ? pos_q + ADDR_W'(BANK_SIZE) : pos_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rast_start) begin
      color_q <= fill_color_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      init_q     <= '0;
      pos_q      <= '0;
      front_q    <= 1'b0;
      wait_q     <= 1'b0;
      fbusy_q    <= 1'b0;
      cmd_q      <= '0;
      valid_q    <= 1'b0;
      tx_valid_q <= 1'b0;
      tx_byte_q  <= '0;
    end else begin
      valid_q    <= 1'b0;
      tx_valid_q <= 1'b0;
      tx_byte_q  <= '0;
      if (start_command_we_i) begin
        cmd_q <= start_command_i;
      end
      unique case (state_q)
        S_INIT: begin
          init_q <= init_q + ADDR_W'(1);
          if (init_q == ADDR_W'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (op)
              dblf_pkg::OP_CLEAR, dblf_pkg::OP_FILL: begin
                state_q <= S_PAINT;
              end
              dblf_pkg::OP_PRESENT: begin
                valid_q <= 1'b1;
                if (!fbusy_q) begin
                  front_q    <= ~front_q;
                  wait_q     <= 1'b1;
                  fbusy_q    <= 1'b1;
                  tx_valid_q <= 1'b1;
                  tx_byte_q  <= cmd_q;
                end
              end
              dblf_pkg::OP_ACK: begin
                valid_q <= 1'b1;
                wait_q  <= 1'b0;
              end
              dblf_pkg::OP_TICK: begin
                if (wait_q) begin
                  valid_q <= 1'b1;
                end else begin
                  state_q <= S_READ;
                end
              end
              default: begin
                valid_q <= 1'b1;
              end
            endcase
          end
        end
        S_PAINT: begin
          if (rast_done) begin
            valid_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_READ: begin
          valid_q    <= 1'b1;
          tx_valid_q <= 1'b1;
          tx_byte_q  <= rd_q;
          wait_q     <= 1'b1;
          if (pos_q == ADDR_W'(BANK_SIZE - 1)) begin
            pos_q   <= '0;
            fbusy_q <= 1'b0;
          end else begin
            pos_q <= pos_q + ADDR_W'(1);
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`include "double_buffered_led_framebuffer_assert.svh"

  `DBLF_ASSERT_IMP(a_no_byte_zero, valid_o && !tx_valid_o, tx_byte_o == '0, "idle byte not zero")
  `DBLF_ASSERT_IMP(a_sent_pending, valid_o && tx_valid_o, ack_pending_o, "byte sent without pending ack")
  `DBLF_ASSERT_IMP(a_no_write_idle, state_q == S_IDLE || state_q == S_READ, !mem_we, "store written outside paint")
  `DBLF_ASSERT_NXT(a_tick_reads, accept && op == dblf_pkg::OP_TICK && !wait_q, state_q == S_READ, "tick did not read")
  `DBLF_ASSERT_IMP(a_valid_not_busy, valid_o, state_q == S_IDLE, "result shown while busy")

endmodule

@@ dv/frame_tx_checker.sv @@
// Frame store checker: watches command and result beats, predicts each result and compares.
module frame_tx_checker #(
  parameter int SCREEN_COLS = dblf_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = dblf_pkg::SCREEN_ROWS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_command_we_i,
  input  logic [dblf_pkg::BYTE_W-1:0]  start_command_i,
  input  logic                         start_i,
  input  logic                         busy_o,
  input  logic [dblf_pkg::OP_W-1:0]    opcode_i,
  input  logic [dblf_pkg::COORD_W-1:0] area_x_i,
  input  logic [dblf_pkg::COORD_W-1:0] area_y_i,
  input  logic [dblf_pkg::COORD_W-1:0] area_width_i,
  input  logic [dblf_pkg::COORD_W-1:0] area_height_i,
  input  logic [dblf_pkg::BYTE_W-1:0]  fill_color_i,
  input  logic                         valid_o,
  input  logic                         tx_valid_o,
  input  logic [dblf_pkg::BYTE_W-1:0]  tx_byte_o,
  input  logic                         frame_in_flight_o,
  input  logic                         ack_pending_o,
  output int                           fail_count_o,
  output int                           due_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BANK_PIXELS = SCREEN_COLS * SCREEN_ROWS;
  localparam int BYTE_W      = dblf_pkg::BYTE_W;
  localparam int OP_W        = dblf_pkg::OP_W;
  localparam int COORD_W     = dblf_pkg::COORD_W;

  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              in_flight;
    logic              ack_pending;
  } tx_report_t;

  logic [BYTE_W-1:0] pixel_mem [2*BANK_PIXELS];
  logic              front_bank;
  int                scan_col;
  int                scan_row;
  logic              awaiting_ack;
  logic              frame_active;
  logic [BYTE_W-1:0] frame_start_byte;
  tx_report_t        reports_due[$];
  int                mismatches;

  function automatic void paint_back_bank(int x0, int y0, int x_end, int y_end,
                                          logic [BYTE_W-1:0] color);
    int base;
    base = front_bank ? 0 : BANK_PIXELS;
    if (x_end > SCREEN_COLS) x_end = SCREEN_COLS;
    if (y_end > SCREEN_ROWS) y_end = SCREEN_ROWS;
    for (int r = y0; r < y_end; r++)
      for (int c = x0; c < x_end; c++)
        pixel_mem[base + r * SCREEN_COLS + c] = color;
  endfunction

  function automatic tx_report_t predict_tx_report(logic [OP_W-1:0] op,
                                                   logic [COORD_W-1:0] ax,
                                                   logic [COORD_W-1:0] ay,
                                                   logic [COORD_W-1:0] aw,
                                                   logic [COORD_W-1:0] ah,
                                                   logic [BYTE_W-1:0] color);
    tx_report_t rpt;
    rpt = '0;
    case (op)
      dblf_pkg::OP_CLEAR: paint_back_bank(0, 0, SCREEN_COLS, SCREEN_ROWS, color);
      dblf_pkg::OP_FILL: paint_back_bank(int'(ax), int'(ay), int'(ax) + int'(aw),
                                         int'(ay) + int'(ah), color);
      dblf_pkg::OP_PRESENT: begin
        if (!frame_active) begin
          front_bank   = ~front_bank;
          awaiting_ack = 1'b1;
          frame_active = 1'b1;
          rpt.tx_valid = 1'b1;
          rpt.tx_byte  = frame_start_byte;
        end
      end
      dblf_pkg::OP_ACK: awaiting_ack = 1'b0;
      dblf_pkg::OP_TICK: begin
        if (!awaiting_ack) begin
          awaiting_ack = 1'b1;
          rpt.tx_valid = 1'b1;
          rpt.tx_byte  = pixel_mem[(front_bank ? BANK_PIXELS : 0)
                                   + scan_row * SCREEN_COLS + scan_col];
          scan_col++;
          if (scan_col >= SCREEN_COLS) begin
            scan_col = 0;
            scan_row++;
            if (scan_row >= SCREEN_ROWS) begin
              scan_row     = 0;
              frame_active = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    rpt.in_flight   = frame_active;
    rpt.ack_pending = awaiting_ack;
    return rpt;
  endfunction

  function automatic void check_field(string label, logic [BYTE_W-1:0] want,
                                      logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    tx_report_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 2 * BANK_PIXELS; i++) pixel_mem[i] = '0;
      front_bank       = 1'b0;
      scan_col         = 0;
      scan_row         = 0;
      awaiting_ack     = 1'b0;
      frame_active     = 1'b0;
      frame_start_byte = '0;
      reports_due.delete();
      mismatches       = 0;
      fail_count_o    <= 0;
      due_count_o     <= 0;
    end else begin
      if (valid_o === 1'b1) begin
        if (reports_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %0b %0h %0b %0b", $time,
                   tx_valid_o, tx_byte_o, frame_in_flight_o, ack_pending_o);
          mismatches++;
        end else begin
          want = reports_due.pop_front();
          check_field("tx_valid", BYTE_W'(want.tx_valid), BYTE_W'(tx_valid_o));
          check_field("tx_byte", want.tx_byte, tx_byte_o);
          check_field("frame_in_flight", BYTE_W'(want.in_flight),
                      BYTE_W'(frame_in_flight_o));
          check_field("ack_pending", BYTE_W'(want.ack_pending), BYTE_W'(ack_pending_o));
        end
      end
      if (start_i === 1'b1 && busy_o === 1'b0)
        reports_due.push_back(predict_tx_report(opcode_i, area_x_i, area_y_i,
                                                area_width_i, area_height_i,
                                                fill_color_i));
      if (start_command_we_i === 1'b1) frame_start_byte = start_command_i;
      fail_count_o <= mismatches;
      due_count_o  <= reports_due.size();
    end
  end

endmodule

@@ dv/testbench.sv @@
// Top of the frame store testbench: clock, reset, command stimulus, watchdog and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OP_W    = dblf_pkg::OP_W;
  localparam int BYTE_W  = dblf_pkg::BYTE_W;
  localparam int COORD_W = dblf_pkg::COORD_W;
  localparam logic [OP_W-1:0] OP_RSVD_A = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_B = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_C = 3'd7;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int PHASE_CMDS     = 290;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               start_command_we_i = 1'b0;
  logic [BYTE_W-1:0]  start_command_i = '0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [OP_W-1:0]    opcode_i = '0;
  logic [COORD_W-1:0] area_x_i = '0;
  logic [COORD_W-1:0] area_y_i = '0;
  logic [COORD_W-1:0] area_width_i = '0;
  logic [COORD_W-1:0] area_height_i = '0;
  logic [BYTE_W-1:0]  fill_color_i = '0;
  logic               valid_o;
  logic               tx_valid_o;
  logic [BYTE_W-1:0]  tx_byte_o;
  logic               frame_in_flight_o;
  logic               ack_pending_o;
  int                 fail_count;
  int                 due_count;
  int                 sender_idle_pct = 0;
  int                 cmds_sent;
  int                 quiet_cycles;

  double_buffered_led_framebuffer dut (.*);

  frame_tx_checker checker_i (
    .clk_i, .rst_ni, .start_command_we_i, .start_command_i, .start_i, .busy_o,
    .opcode_i, .area_x_i, .area_y_i, .area_width_i, .area_height_i, .fill_color_i,
    .valid_o, .tx_valid_o, .tx_byte_o, .frame_in_flight_o, .ack_pending_o,
    .fail_count_o(fail_count), .due_count_o(due_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && busy_o === 1'b0) || valid_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] ax,
                          input logic [COORD_W-1:0] ay, input logic [COORD_W-1:0] aw,
                          input logic [COORD_W-1:0] ah, input logic [BYTE_W-1:0] color);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    opcode_i      <= op;
    area_x_i      <= ax;
    area_y_i      <= ay;
    area_width_i  <= aw;
    area_height_i <= ah;
    fill_color_i  <= color;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    cmds_sent++;
  endtask

  task automatic send_random_fields(input logic [OP_W-1:0] op);
    send_cmd(op, 8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
             8'($urandom()));
  endtask

  task automatic wait_for_drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (due_count != 0 || busy_o !== 1'b0) @(posedge clk_i);
  endtask

  task automatic load_start_command(input logic [BYTE_W-1:0] cmd);
    wait_for_drain();
    start_command_we_i <= 1'b1;
    start_command_i    <= cmd;
    @(posedge clk_i);
    start_command_we_i <= 1'b0;
  endtask

  task automatic run_random_cmds(input int target);
    int pick;
    int stop_at;
    stop_at = cmds_sent + target;
    while (cmds_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        // tick/ack pairs advance the scan through the front bank
        repeat ($urandom_range(2, 20)) begin
          send_random_fields(dblf_pkg::OP_TICK);
          send_random_fields(dblf_pkg::OP_ACK);
        end
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 3) == 0) send_random_fields(dblf_pkg::OP_CLEAR);
          else if ($urandom_range(0, 7) == 0) send_random_fields(dblf_pkg::OP_FILL);
          else send_cmd(dblf_pkg::OP_FILL, 8'($urandom_range(0, 40)),
                        8'($urandom_range(0, 20)), 8'($urandom_range(0, 12)),
                        8'($urandom_range(0, 8)), 8'($urandom()));
        end
      end else if (pick < 90) begin
        send_random_fields(dblf_pkg::OP_PRESENT);
        send_random_fields(dblf_pkg::OP_ACK);
      end else begin
        repeat ($urandom_range(1, 6)) send_random_fields(3'($urandom_range(0, 7)));
      end
      if ($urandom_range(0, 24) == 0) wait_for_drain();
    end
  endtask

  initial begin
    int idle_by_phase [4];
    logic [BYTE_W-1:0] cmd_by_phase [4];
    idle_by_phase = '{0, 55, 0, 11};
    cmd_by_phase  = '{8'hFF, 8'h00, 8'($urandom()), 8'hA5};
    cmds_sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait_for_drain();
    send_cmd(dblf_pkg::OP_CLEAR,   8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
    send_cmd(dblf_pkg::OP_FILL,    8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00);
    send_cmd(dblf_pkg::OP_FILL,    8'h1F, 8'h0F, 8'h01, 8'h01, 8'h5A);
    send_cmd(dblf_pkg::OP_FILL,    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(dblf_pkg::OP_FILL,    8'h20, 8'h00, 8'h04, 8'h04, 8'h11);
    send_cmd(dblf_pkg::OP_FILL,    8'h03, 8'h00, 8'h00, 8'h10, 8'h22);
    send_cmd(dblf_pkg::OP_FILL,    8'h00, 8'h10, 8'h04, 8'h04, 8'h33);
    send_cmd(dblf_pkg::OP_FILL,    8'h05, 8'h02, 8'h01, 8'h0A, 8'hC3);
    send_cmd(dblf_pkg::OP_FILL,    8'h00, 8'h07, 8'h20, 8'h01, 8'h3C);
    send_cmd(dblf_pkg::OP_TICK,    8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(dblf_pkg::OP_TICK,    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(dblf_pkg::OP_ACK,     8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(dblf_pkg::OP_ACK,     8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(dblf_pkg::OP_PRESENT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(dblf_pkg::OP_PRESENT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(dblf_pkg::OP_TICK,    8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(dblf_pkg::OP_ACK,     8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(dblf_pkg::OP_TICK,    8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(dblf_pkg::OP_ACK,     8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_RSVD_A,            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(OP_RSVD_B,            8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_RSVD_C,            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

    for (int p = 0; p < 4; p++) begin
      load_start_command(cmd_by_phase[p]);
      sender_idle_pct = idle_by_phase[p];
      run_random_cmds(PHASE_CMDS);
    end

    wait_for_drain();
    repeat (520) @(posedge clk_i);
    if (fail_count == 0 && due_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ double_buffered_led_framebuffer.f @@
+incdir+hdl
hdl/dblf_pkg.sv
hdl/dblf_raster.sv
hdl/double_buffered_led_framebuffer.sv
dv/frame_tx_checker.sv
dv/testbench.sv
